>>> rtl/core/shift_array_insert_delete_find_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shift array unit
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHIFT_ARRAY_INSERT_DELETE_FIND_UNIT_DEFINES_SVH
`define SHIFT_ARRAY_INSERT_DELETE_FIND_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define SADF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define SADF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sadf_pkg.sv
// ----------------------------------------------------------------------------
// Shift array unit package
// Operation codes, transaction payloads and controller/datapath types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sadf_pkg;

  localparam int unsigned IndexW = 6;
  localparam int unsigned ValueW = 32;
  localparam int unsigned FidxW  = 5;
  localparam int unsigned CountW = 6;

  localparam logic StatusDone   = 1'b0;
  localparam logic StatusReject = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [IndexW-1:0]        index;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [FidxW-1:0]  found_index;
    logic [CountW-1:0] count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PROBE,
    ST_SHIFT,
    ST_DRAIN,
    ST_FINAL,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted request
    logic init;      // set the walk pointer for the operation
    logic probe;     // read the slot addressed by the request index
    logic step;      // read the slot at the walk pointer and advance it
    logic final_op;  // final write and count update of the operation
    logic reject;    // mark the operation as rejected
    logic finish;    // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic reject_early;  // index or count check fails
    logic at_top;        // request index is the last slot
    logic slot_empty;    // probed slot holds zero
    logic last;          // walk pointer is at the end of its range
  } dp_stat_t;

endpackage

>>> rtl/core/sadf_if.sv
// ----------------------------------------------------------------------------
// Shift array unit channel interfaces
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sadf_req_if;
  logic          valid;
  logic          ready;
  sadf_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sadf_rsp_if;
  logic          valid;
  logic          ready;
  sadf_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/sadf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sadf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/sadf_ctrl.sv
// ----------------------------------------------------------------------------
// Shift array unit controller
// Sequences probe, walk and final write of each operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shift_array_insert_delete_find_unit_defines.svh"

module sadf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               rsp_ready_i,
  output logic               rsp_valid_o,
  input  sadf_pkg::dp_stat_t stat_i,
  output sadf_pkg::dp_cmd_t  cmd_o
);

  import sadf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.reject_early) begin
          state_d = ST_DONE;
        end else begin
          unique case (stat_i.op)
            OP_INSERT, OP_MODIFY: state_d = ST_PROBE;
            OP_DELETE:            state_d = stat_i.at_top ? ST_FINAL : ST_SHIFT;
            OP_FIND:              state_d = ST_SHIFT;
            default:              state_d = ST_DONE;
          endcase
        end
      end
      ST_PROBE: begin
        unique case (stat_i.op)
          OP_INSERT: state_d = (stat_i.slot_empty || stat_i.at_top) ? ST_FINAL : ST_SHIFT;
          OP_MODIFY: state_d = stat_i.slot_empty ? ST_DONE : ST_FINAL;
          default:   state_d = ST_FINAL;
        endcase
      end
      ST_SHIFT: begin
        if (stat_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_FINAL;
      ST_FINAL: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_DECODE: begin
        cmd_o.init   = 1'b1;
        cmd_o.reject = stat_i.reject_early;
        cmd_o.probe  = !stat_i.reject_early &&
                       (stat_i.op == OP_INSERT || stat_i.op == OP_MODIFY);
      end
      ST_PROBE: begin
        cmd_o.reject = (stat_i.op == OP_MODIFY) && stat_i.slot_empty;
      end
      ST_SHIFT: cmd_o.step     = 1'b1;
      ST_DRAIN: cmd_o.step     = 1'b0;
      ST_FINAL: cmd_o.final_op = 1'b1;
      ST_DONE:  cmd_o.finish   = !out_valid_q || rsp_ready_i;
      default:  cmd_o          = '0;
    endcase

    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

  `SADF_ASSERT_IMPL(a_modify_no_walk, clk_i, rst_ni, state_q == ST_SHIFT, stat_i.op != OP_MODIFY, "modify entered a walk")
  `SADF_ASSERT_NEXT(a_finish_shows_result, clk_i, rst_ni, cmd_o.finish, out_valid_q && state_q == ST_IDLE, "result not presented after finish")

endmodule

>>> rtl/core/sadf_dp.sv
// ----------------------------------------------------------------------------
// Shift array unit datapath
// Slot memory, walk pointer, element count and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shift_array_insert_delete_find_unit_defines.svh"

module sadf_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sadf_pkg::req_t     req_i,
  input  sadf_pkg::dp_cmd_t  cmd_i,
  output sadf_pkg::dp_stat_t stat_o,
  output sadf_pkg::rsp_t     rsp_o
);

  import sadf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > IndexW) ? CW : IndexW;

  op_e               op_q;
  logic [IndexW-1:0] idx_q;
  logic [ValueW-1:0] val_q;
  logic [AW-1:0]     ptr_q;
  logic              pend_q;
  logic [AW-1:0]     paddr_q;
  logic              pvld_q;
  logic [CW-1:0]     cnt_q;
  logic [DEPTH-1:0]  valid_q;
  logic              reject_q;
  logic              found_q;
  logic [AW-1:0]     fidx_q;
  rsp_t              rsp_q;

  logic              in_range;
  logic [AW-1:0]     idx_a;
  logic [ValueW-1:0] rd_data;
  logic [ValueW-1:0] slot_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;

  assign in_range  = XW'(idx_q) < XW'(DEPTH);
  assign idx_a     = AW'(idx_q);
  // Slots never written since reset read as empty.
  assign slot_data = pvld_q ? rd_data : '0;

  always_comb begin
    stat_o            = '0;
    stat_o.op         = op_q;
    stat_o.at_top     = XW'(idx_q) == XW'(DEPTH - 1);
    stat_o.slot_empty = slot_data == '0;
    unique case (op_q)
      OP_INSERT: stat_o.reject_early = !in_range || (cnt_q >= CW'(DEPTH));
      OP_DELETE: stat_o.reject_early = !in_range || (cnt_q == '0);
      OP_MODIFY: stat_o.reject_early = !in_range;
      default:   stat_o.reject_early = 1'b0;
    endcase
    if (op_q == OP_INSERT) begin
      stat_o.last = ptr_q == idx_a;
    end else begin
      stat_o.last = ptr_q == AW'(DEPTH - 1);
    end
  end

  assign rd_en   = cmd_i.probe || cmd_i.step;
  assign rd_addr = cmd_i.probe ? idx_a : ptr_q;

  // Each write of the walk comes in the cycle after its read; the final write comes last.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    priority if (pend_q) begin
      ram_wdata = slot_data;
      if (op_q == OP_INSERT) begin
        ram_we    = 1'b1;
        ram_waddr = paddr_q + AW'(1);
      end else if (op_q == OP_DELETE) begin
        ram_we    = 1'b1;
        ram_waddr = paddr_q - AW'(1);
      end
    end else if (cmd_i.final_op) begin
      unique case (op_q)
        OP_INSERT, OP_MODIFY: begin
          ram_we    = 1'b1;
          ram_waddr = idx_a;
          ram_wdata = val_q;
        end
        OP_DELETE: begin
          ram_we    = 1'b1;
          ram_waddr = AW'(DEPTH - 1);
          ram_wdata = '0;
        end
        default: ram_we = 1'b0;
      endcase
    end else begin
      ram_we = 1'b0;
    end
  end

  sadf_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= '0;
      pend_q  <= 1'b0;
      pvld_q  <= 1'b0;
    end else begin
      pend_q <= cmd_i.step;
      if (rd_en) begin
        pvld_q <= valid_q[rd_addr];
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (cmd_i.final_op && op_q == OP_INSERT) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.final_op && op_q == OP_DELETE) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= req_i.op;
      idx_q    <= req_i.index;
      val_q    <= req_i.value;
      reject_q <= 1'b0;
      found_q  <= 1'b0;
      fidx_q   <= '0;
    end else begin
      if (cmd_i.reject) begin
        reject_q <= 1'b1;
      end
      if (pend_q && op_q == OP_FIND && !found_q && slot_data == val_q) begin
        found_q <= 1'b1;
        fidx_q  <= paddr_q;
      end
    end
    if (cmd_i.init) begin
      unique case (op_q)
        OP_INSERT: ptr_q <= AW'(DEPTH - 2);
        OP_DELETE: ptr_q <= idx_a + AW'(1);
        default:   ptr_q <= '0;
      endcase
    end else if (cmd_i.step) begin
      ptr_q <= (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end
    if (cmd_i.step) begin
      paddr_q <= ptr_q;
    end
    if (cmd_i.finish) begin
      rsp_q.status      <= reject_q ? StatusReject : StatusDone;
      rsp_q.found       <= found_q;
      rsp_q.found_index <= FidxW'(fidx_q);
      rsp_q.count       <= CountW'(cnt_q);
    end
  end

  assign rsp_o = rsp_q;

  `SADF_ASSERT_IMPL(a_no_rw_collision, clk_i, rst_ni, ram_we && rd_en,
                    ram_waddr != rd_addr, "slot read and written at one address")
  `SADF_ASSERT_NEXT(a_count_only_final, clk_i, rst_ni, !cmd_i.final_op,
                    $stable(cnt_q), "count changed outside the final write")
  `SADF_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH),
                    "count above capacity")

endmodule

>>> rtl/core/shift_array_insert_delete_find_unit.sv
// ----------------------------------------------------------------------------
// Shift array insert/delete/find unit
// Ordered list in a slot memory with insert, delete, find and modify.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i as transactions carrying op, index and
// value; every request gives exactly one response transaction on rsp_o with
// status, found, found_index and the element count after the operation.
// One request is worked on at a time. A find walks all DEPTH slots before its
// response is registered. An insert into an occupied slot at index i below the
// last shifts DEPTH - 1 - i slots, and so does a delete at index i below the
// last. A request rejected on its index or count goes straight to its
// response; a delete at the last slot, a modify and the other inserts need no
// walk. The next request is taken only after the previous response is
// registered. Throughput is set by the single read port of the slot memory,
// which moves one slot per cycle during a walk.
// Reset clears the element count and marks every slot empty through one flag
// per slot; no clearing pass is needed and requests are taken right away.
// When the receiver stalls, the response waits in the output register while
// the next request is accepted and worked on; it completes only once the
// output register is free.
`timescale 1ns / 1ps

module shift_array_insert_delete_find_unit #(
  parameter int unsigned DEPTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  sadf_req_if.sink   req_i,
  sadf_rsp_if.source rsp_o
);

  import sadf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     req_ready;
  logic     rsp_valid;

  // The controller only sequences and flags the response; all data storage lives in the datapath.
  sadf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sadf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i.payload),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o.payload)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

endmodule
